// ===== src/mde_pkg.sv =====
package mde_pkg;

   // Primary opcodes.
   localparam logic [5:0] OP_R     = 6'h00;
   localparam logic [5:0] OP_J     = 6'h02;
   localparam logic [5:0] OP_JAL   = 6'h03;
   localparam logic [5:0] OP_BEQ   = 6'h04;
   localparam logic [5:0] OP_BNE   = 6'h05;
   localparam logic [5:0] OP_ADDI  = 6'h08;
   localparam logic [5:0] OP_ADDIU = 6'h09;
   localparam logic [5:0] OP_SLTI  = 6'h0A;
   localparam logic [5:0] OP_SLTIU = 6'h0B;
   localparam logic [5:0] OP_ANDI  = 6'h0C;
   localparam logic [5:0] OP_ORI   = 6'h0D;
   localparam logic [5:0] OP_LUI   = 6'h0F;
   localparam logic [5:0] OP_LW    = 6'h23;
   localparam logic [5:0] OP_SW    = 6'h2B;

   // R-type function codes.
   localparam logic [5:0] FN_SLL  = 6'h00;
   localparam logic [5:0] FN_SRL  = 6'h02;
   localparam logic [5:0] FN_JR   = 6'h08;
   localparam logic [5:0] FN_SYS  = 6'h0C;
   localparam logic [5:0] FN_ADD  = 6'h20;
   localparam logic [5:0] FN_ADDU = 6'h21;
   localparam logic [5:0] FN_SUB  = 6'h22;
   localparam logic [5:0] FN_SUBU = 6'h23;
   localparam logic [5:0] FN_AND  = 6'h24;
   localparam logic [5:0] FN_OR   = 6'h25;
   localparam logic [5:0] FN_NOR  = 6'h27;
   localparam logic [5:0] FN_SLT  = 6'h2A;
   localparam logic [5:0] FN_SLTU = 6'h2B;

   // Status codes.
   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_OVF   = 3'd1;
   localparam logic [2:0] ST_BADOP = 3'd2;
   localparam logic [2:0] ST_BADFN = 3'd3;
   localparam logic [2:0] ST_HALT  = 3'd4;

   // Internal ALU operations.
   localparam logic [3:0] ALU_NONE = 4'd0;
   localparam logic [3:0] ALU_SLL  = 4'd1;
   localparam logic [3:0] ALU_SRL  = 4'd2;
   localparam logic [3:0] ALU_ADD  = 4'd3;
   localparam logic [3:0] ALU_SUB  = 4'd4;
   localparam logic [3:0] ALU_AND  = 4'd5;
   localparam logic [3:0] ALU_OR   = 4'd6;
   localparam logic [3:0] ALU_NOR  = 4'd7;
   localparam logic [3:0] ALU_SLT  = 4'd8;
   localparam logic [3:0] ALU_SLTU = 4'd9;
   localparam logic [3:0] ALU_PASS = 4'd10;

   localparam logic [4:0]  LINK_REG  = 5'd31;
   localparam int unsigned LUI_SHIFT = 16;
   localparam logic [31:0] LINK_OFS  = 32'h0000_0004;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  alu_op;
      logic        ovf_check;
      logic [4:0]  shamt;
      logic [31:0] op_a;
      logic [31:0] op_b;
      logic        rd_write;
      logic [4:0]  dest_reg;
      logic        load_en;
      logic        store_en;
      logic        load_to_rd;
      logic        branch_eq;
      logic        branch_ne;
      logic        jump;
      logic        jump_reg;
   } dec_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] alu_result;
      logic [4:0]  dest_reg;
      logic        rd_write;
      logic        load_en;
      logic        store_en;
      logic        load_to_rd;
      logic [31:0] store_data;
      logic        jump_taken;
      logic [31:0] redirect_pc;
      logic        flush_fetch;
   } exe_type;

endpackage

// ===== src/mde_decode.sv =====
module mde_decode (
   input  logic [31:0]      instruction,
   input  logic [31:0]      rs_operand,
   input  logic [31:0]      rt_operand,
   input  logic [31:0]      next_pc,
   output mde_pkg::dec_type dec
);

   logic [5:0]  opcode;
   logic [5:0]  funct;
   logic [4:0]  rt_field;
   logic [4:0]  rd_field;
   logic [15:0] imm;
   logic [31:0] imm_sx;
   logic [31:0] imm_zx;

   assign opcode   = instruction[31:26];
   assign funct    = instruction[5:0];
   assign rt_field = instruction[20:16];
   assign rd_field = instruction[15:11];
   assign imm      = instruction[15:0];
   assign imm_sx   = {{16{imm[15]}}, imm};
   assign imm_zx   = {16'h0000, imm};

   always_comb begin
      dec            = '0;
      dec.status     = mde_pkg::ST_OK;
      dec.alu_op     = mde_pkg::ALU_NONE;
      dec.shamt      = instruction[10:6];
      dec.op_a       = rs_operand;
      dec.op_b       = rt_operand;
      unique case (opcode)
         mde_pkg::OP_R: begin
            if (funct == mde_pkg::FN_JR) begin
               dec.jump_reg = 1'b1;
            end else begin
               dec.rd_write = 1'b1;
               dec.dest_reg = rd_field;
               unique case (funct)
                  mde_pkg::FN_SLL:  dec.alu_op = mde_pkg::ALU_SLL;
                  mde_pkg::FN_SRL:  dec.alu_op = mde_pkg::ALU_SRL;
                  mde_pkg::FN_ADD: begin
                     dec.alu_op    = mde_pkg::ALU_ADD;
                     dec.ovf_check = 1'b1;
                  end
                  mde_pkg::FN_ADDU: dec.alu_op = mde_pkg::ALU_ADD;
                  mde_pkg::FN_SUB: begin
                     dec.alu_op    = mde_pkg::ALU_SUB;
                     dec.ovf_check = 1'b1;
                  end
                  mde_pkg::FN_SUBU: dec.alu_op = mde_pkg::ALU_SUB;
                  mde_pkg::FN_AND:  dec.alu_op = mde_pkg::ALU_AND;
                  mde_pkg::FN_OR:   dec.alu_op = mde_pkg::ALU_OR;
                  mde_pkg::FN_NOR:  dec.alu_op = mde_pkg::ALU_NOR;
                  mde_pkg::FN_SLT:  dec.alu_op = mde_pkg::ALU_SLT;
                  mde_pkg::FN_SLTU: dec.alu_op = mde_pkg::ALU_SLTU;
                  mde_pkg::FN_SYS:  dec.status = mde_pkg::ST_HALT;
                  default:          dec.status = mde_pkg::ST_BADFN;
               endcase
            end
         end
         mde_pkg::OP_LW: begin
            dec.alu_op     = mde_pkg::ALU_ADD;
            dec.op_b       = imm_sx;
            dec.rd_write   = 1'b1;
            dec.dest_reg   = rt_field;
            dec.load_en    = 1'b1;
            dec.load_to_rd = 1'b1;
         end
         mde_pkg::OP_SW: begin
            dec.alu_op   = mde_pkg::ALU_ADD;
            dec.op_b     = imm_sx;
            dec.store_en = 1'b1;
         end
         mde_pkg::OP_ADDI: begin
            dec.alu_op    = mde_pkg::ALU_ADD;
            dec.ovf_check = 1'b1;
            dec.op_b      = imm_sx;
            dec.rd_write  = 1'b1;
            dec.dest_reg  = rt_field;
         end
         mde_pkg::OP_ADDIU: begin
            dec.alu_op   = mde_pkg::ALU_ADD;
            dec.op_b     = imm_sx;
            dec.rd_write = 1'b1;
            dec.dest_reg = rt_field;
         end
         mde_pkg::OP_SLTI: begin
            dec.alu_op   = mde_pkg::ALU_SLT;
            dec.op_b     = imm_sx;
            dec.rd_write = 1'b1;
            dec.dest_reg = rt_field;
         end
         mde_pkg::OP_SLTIU: begin
            dec.alu_op   = mde_pkg::ALU_SLTU;
            dec.op_b     = imm_sx;
            dec.rd_write = 1'b1;
            dec.dest_reg = rt_field;
         end
         mde_pkg::OP_ANDI: begin
            dec.alu_op   = mde_pkg::ALU_AND;
            dec.op_b     = imm_zx;
            dec.rd_write = 1'b1;
            dec.dest_reg = rt_field;
         end
         mde_pkg::OP_ORI: begin
            dec.alu_op   = mde_pkg::ALU_OR;
            dec.op_b     = imm_zx;
            dec.rd_write = 1'b1;
            dec.dest_reg = rt_field;
         end
         mde_pkg::OP_LUI: begin
            dec.alu_op   = mde_pkg::ALU_PASS;
            dec.op_b     = imm_zx << mde_pkg::LUI_SHIFT;
            dec.rd_write = 1'b1;
            dec.dest_reg = rt_field;
         end
         mde_pkg::OP_BEQ:  dec.branch_eq = 1'b1;
         mde_pkg::OP_BNE:  dec.branch_ne = 1'b1;
         mde_pkg::OP_J:    dec.jump      = 1'b1;
         mde_pkg::OP_JAL: begin
            // The link value is formed by the ALU adder from the next PC.
            dec.jump     = 1'b1;
            dec.alu_op   = mde_pkg::ALU_ADD;
            dec.op_a     = next_pc;
            dec.op_b     = mde_pkg::LINK_OFS;
            dec.rd_write = 1'b1;
            dec.dest_reg = mde_pkg::LINK_REG;
         end
         default: dec.status = mde_pkg::ST_BADOP;
      endcase
   end

endmodule

// ===== src/mde_execute.sv =====
module mde_execute (
   input  mde_pkg::dec_type dec,
   input  logic [31:0]      rs_operand,
   input  logic [31:0]      rt_operand,
   input  logic [31:0]      next_pc,
   input  logic [25:0]      jump_index,
   output mde_pkg::exe_type exe
);

   logic [31:0] sum;
   logic [31:0] diff;
   logic [31:0] result;
   logic        overflow;
   logic        branch_taken;
   logic [31:0] branch_target;
   logic [31:0] region_target;
   logic [31:0] offset;

   assign sum  = dec.op_a + dec.op_b;
   assign diff = dec.op_a - dec.op_b;

   always_comb begin
      result   = '0;
      overflow = 1'b0;
      unique case (dec.alu_op)
         mde_pkg::ALU_SLL:  result = dec.op_b << dec.shamt;
         mde_pkg::ALU_SRL:  result = dec.op_b >> dec.shamt;
         mde_pkg::ALU_ADD: begin
            result   = sum;
            overflow = ~(dec.op_a[31] ^ dec.op_b[31]) & (dec.op_a[31] ^ sum[31]);
         end
         mde_pkg::ALU_SUB: begin
            result   = diff;
            overflow = (dec.op_a[31] ^ dec.op_b[31]) & (dec.op_a[31] ^ diff[31]);
         end
         mde_pkg::ALU_AND:  result = dec.op_a & dec.op_b;
         mde_pkg::ALU_OR:   result = dec.op_a | dec.op_b;
         mde_pkg::ALU_NOR:  result = ~(dec.op_a | dec.op_b);
         mde_pkg::ALU_SLT:  result = {31'd0, $signed(dec.op_a) < $signed(dec.op_b)};
         mde_pkg::ALU_SLTU: result = {31'd0, dec.op_a < dec.op_b};
         mde_pkg::ALU_PASS: result = dec.op_b;
         default:           result = '0;
      endcase
   end

   // Branch offset is the sign-extended immediate in words.
   assign offset        = {{14{jump_index[15]}}, jump_index[15:0], 2'b00};
   assign branch_target = next_pc + offset;
   assign region_target = {next_pc[31:28], jump_index, 2'b00};
   assign branch_taken  = (dec.branch_eq && (rs_operand == rt_operand))
                       || (dec.branch_ne && (rs_operand != rt_operand));

   always_comb begin
      exe             = '0;
      exe.status      = (dec.status == mde_pkg::ST_OK && dec.ovf_check && overflow)
                      ? mde_pkg::ST_OVF : dec.status;
      exe.alu_result  = result;
      exe.rd_write    = dec.rd_write;
      exe.dest_reg    = dec.rd_write ? dec.dest_reg : 5'd0;
      exe.load_en     = dec.load_en;
      exe.store_en    = dec.store_en;
      exe.load_to_rd  = dec.load_to_rd;
      exe.store_data  = dec.store_en ? rt_operand : 32'd0;
      exe.flush_fetch = dec.jump_reg;
      priority if (dec.jump_reg) begin
         exe.jump_taken  = 1'b1;
         exe.redirect_pc = rs_operand;
      end else if (dec.jump) begin
         exe.jump_taken  = 1'b1;
         exe.redirect_pc = region_target;
      end else if (branch_taken) begin
         exe.jump_taken  = 1'b1;
         exe.redirect_pc = branch_target;
      end else begin
         exe.jump_taken  = 1'b0;
         exe.redirect_pc = 32'd0;
      end
   end

endmodule

// ===== src/mips_decode_execute_core.sv =====
// An accepted request beat passes through stage 1, stage 2 and stage 3 to its
// response beat. Throughput: one instruction per cycle when the output is not
// stalled; each stage advances on its own valid bit, so bubbles are squeezed out
// while the output is stalled. Reset: synchronous, active high; clears all stage
// valid bits, payload registers are not reset.
module mips_decode_execute_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_instruction,
   input  logic [31:0] req_rs_operand,
   input  logic [31:0] req_rt_operand,
   input  logic [31:0] req_next_pc,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_alu_result,
   output logic [4:0]  rsp_dest_reg,
   output logic        rsp_rd_write,
   output logic        rsp_load_en,
   output logic        rsp_store_en,
   output logic        rsp_load_to_rd,
   output logic [31:0] rsp_store_data,
   output logic        rsp_jump_taken,
   output logic [31:0] rsp_redirect_pc,
   output logic        rsp_flush_fetch
);

   // Stage 1 decodes the word and selects the ALU operands.
   // Stage 2 runs the ALU, the branch compare and the target adders.
   // Stage 3 applies the status squash and holds the response beat.

   mde_pkg::dec_type dec_in, dec_ff;
   mde_pkg::exe_type exe_in, exe_ff, out_in, out_ff;
   logic [31:0]      s1_rs_ff, s1_rt_ff, s1_npc_ff;
   logic [25:0]      s1_index_ff;
   logic             s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic             s1_move, s2_move, s3_move;

   // A stage may load whenever it is empty or the stage after it moves on.
   assign s3_move   = !s3_valid_ff || !rsp_stall;
   assign s2_move   = !s2_valid_ff || s3_move;
   assign s1_move   = !s1_valid_ff || s2_move;
   assign req_stall = !s1_move;

   mde_decode u_decode (
      .instruction (req_instruction),
      .rs_operand  (req_rs_operand),
      .rt_operand  (req_rt_operand),
      .next_pc     (req_next_pc),
      .dec         (dec_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_move) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         dec_ff      <= dec_in;
         s1_rs_ff    <= req_rs_operand;
         s1_rt_ff    <= req_rt_operand;
         s1_npc_ff   <= req_next_pc;
         s1_index_ff <= req_instruction[25:0];
      end
   end

   mde_execute u_execute (
      .dec        (dec_ff),
      .rs_operand (s1_rs_ff),
      .rt_operand (s1_rt_ff),
      .next_pc    (s1_npc_ff),
      .jump_index (s1_index_ff),
      .exe        (exe_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_move) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_move) begin
         exe_ff <= exe_in;
      end
   end

   // Any non-ok status turns the instruction into a no-op: only the
   // status field survives.
   always_comb begin
      if (exe_ff.status == mde_pkg::ST_OK) begin
         out_in = exe_ff;
      end else begin
         out_in        = '0;
         out_in.status = exe_ff.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_move) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_move) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid       = s3_valid_ff;
   assign rsp_status      = out_ff.status;
   assign rsp_alu_result  = out_ff.alu_result;
   assign rsp_dest_reg    = out_ff.dest_reg;
   assign rsp_rd_write    = out_ff.rd_write;
   assign rsp_load_en     = out_ff.load_en;
   assign rsp_store_en    = out_ff.store_en;
   assign rsp_load_to_rd  = out_ff.load_to_rd;
   assign rsp_store_data  = out_ff.store_data;
   assign rsp_jump_taken  = out_ff.jump_taken;
   assign rsp_redirect_pc = out_ff.redirect_pc;
   assign rsp_flush_fetch = out_ff.flush_fetch;

endmodule

// ===== src/mde_checker.sv =====
module mde_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [31:0] req_instruction,
   input logic [31:0] req_rs_operand,
   input logic [31:0] req_rt_operand,
   input logic [31:0] req_next_pc,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_status,
   input logic [31:0] rsp_alu_result,
   input logic [4:0]  rsp_dest_reg,
   input logic        rsp_rd_write,
   input logic        rsp_load_en,
   input logic        rsp_store_en,
   input logic        rsp_load_to_rd,
   input logic [31:0] rsp_store_data,
   input logic        rsp_jump_taken,
   input logic [31:0] rsp_redirect_pc,
   input logic        rsp_flush_fetch
);

   // A stalled response beat stays and holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_alu_result)
         && $stable(rsp_status) && $stable(rsp_redirect_pc))
      else $error("stalled response beat changed");

   // After reset the pipeline holds no beat.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response beat after reset");

   // A faulting or halting instruction has no side effect.
   a_squash: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != mde_pkg::ST_OK |->
         rsp_alu_result == 32'd0 && !rsp_rd_write && !rsp_load_en
         && !rsp_store_en && !rsp_jump_taken && rsp_store_data == 32'd0)
      else $error("non-ok status with live fields");

   // No destination register without a write, no store data without a store.
   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_rd_write || rsp_dest_reg == 5'd0)
         && (rsp_store_en || rsp_store_data == 32'd0))
      else $error("unused field not zero");

   // A fetch flush always comes with a redirect; no target without one.
   a_redirect: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_jump_taken |-> !rsp_flush_fetch && rsp_redirect_pc == 32'd0)
      else $error("flush or target without redirect");

endmodule

bind mips_decode_execute_core mde_checker u_mde_checker (.*);

// ===== test/tb.sv =====
module tb;

   // Codes that no opcode or funct decoder in the subset recognizes.
   localparam logic [5:0] OP_UNUSED = 6'h3F;
   localparam logic [5:0] FN_UNUSED = 6'h3F;

   // Cycles without any accepted beat on either channel before the run is abandoned.
   localparam int unsigned STALL_LIMIT = 4000;
   // The pipeline is three stages deep; extra cycles at the end catch stray beats.
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned BEATS_PER_PHASE = 350;

   // The scoreboard predicts the stage's output for every accepted instruction
   // and holds the predictions in order until the matching response beat arrives.
   class decode_exec_scoreboard;
      mde_pkg::exe_type pending_results[$];
      int               mismatches;

      function new();
         mismatches = 0;
      endfunction

      task report_mismatch(input string what, input logic [31:0] got,
                           input logic [31:0] want);
         if (mismatches < 100)
            $display("mismatch: %s got %h expected %h", what, got, want);
         mismatches++;
      endtask

      function logic [2:0] alu_compute(input logic [5:0] fn, input logic [31:0] a,
                                       input logic [31:0] b, input logic [4:0] sh,
                                       output logic [31:0] r);
         logic [2:0] st;
         st = mde_pkg::ST_OK;
         r  = '0;
         case (fn)
            mde_pkg::FN_SLL:  r = b << sh;
            mde_pkg::FN_SRL:  r = b >> sh;
            mde_pkg::FN_ADD: begin
               r = a + b;
               if (a[31] == b[31] && r[31] != a[31]) st = mde_pkg::ST_OVF;
            end
            mde_pkg::FN_ADDU: r = a + b;
            mde_pkg::FN_SUB: begin
               r = a - b;
               if (a[31] != b[31] && r[31] != a[31]) st = mde_pkg::ST_OVF;
            end
            mde_pkg::FN_SUBU: r = a - b;
            mde_pkg::FN_AND:  r = a & b;
            mde_pkg::FN_OR:   r = a | b;
            mde_pkg::FN_NOR:  r = ~(a | b);
            mde_pkg::FN_SLT:  r = {31'd0, $signed(a) < $signed(b)};
            mde_pkg::FN_SLTU: r = {31'd0, a < b};
            mde_pkg::FN_SYS:  st = mde_pkg::ST_HALT;
            default:          st = mde_pkg::ST_BADFN;
         endcase
         return st;
      endfunction

      function mde_pkg::exe_type decode_execute(input logic [31:0] ins,
                                                input logic [31:0] rs,
                                                input logic [31:0] rt,
                                                input logic [31:0] npc);
         mde_pkg::exe_type e;
         logic [5:0]  op, fn;
         logic [4:0]  sh, rd_f, rt_f, dst;
         logic [15:0] imm;
         logic [31:0] sx, btgt, jtgt, res;
         logic [2:0]  st;
         logic        rw;
         e    = '0;
         res  = '0;
         st   = mde_pkg::ST_OK;
         rw   = 1'b0;
         dst  = '0;
         op   = ins[31:26];
         fn   = ins[5:0];
         sh   = ins[10:6];
         rd_f = ins[15:11];
         rt_f = ins[20:16];
         imm  = ins[15:0];
         sx   = {{16{imm[15]}}, imm};
         btgt = npc + {sx[29:0], 2'b00};
         jtgt = {npc[31:28], ins[25:0], 2'b00};
         case (op)
            mde_pkg::OP_R: begin
               if (fn == mde_pkg::FN_JR) begin
                  e.jump_taken  = 1'b1;
                  e.redirect_pc = rs;
                  e.flush_fetch = 1'b1;
               end else begin
                  st  = alu_compute(fn, rs, rt, sh, res);
                  rw  = 1'b1;
                  dst = rd_f;
               end
            end
            mde_pkg::OP_LW: begin
               res = rs + sx;
               rw  = 1'b1;
               dst = rt_f;
               e.load_en    = 1'b1;
               e.load_to_rd = 1'b1;
            end
            mde_pkg::OP_SW: begin
               res = rs + sx;
               e.store_en   = 1'b1;
               e.store_data = rt;
            end
            mde_pkg::OP_ADDI: begin
               st = alu_compute(mde_pkg::FN_ADD, rs, sx, 5'd0, res);
               rw = 1'b1; dst = rt_f;
            end
            mde_pkg::OP_ADDIU: begin
               st = alu_compute(mde_pkg::FN_ADDU, rs, sx, 5'd0, res);
               rw = 1'b1; dst = rt_f;
            end
            mde_pkg::OP_SLTI: begin
               st = alu_compute(mde_pkg::FN_SLT, rs, sx, 5'd0, res);
               rw = 1'b1; dst = rt_f;
            end
            mde_pkg::OP_SLTIU: begin
               st = alu_compute(mde_pkg::FN_SLTU, rs, sx, 5'd0, res);
               rw = 1'b1; dst = rt_f;
            end
            mde_pkg::OP_ANDI: begin
               res = rs & {16'd0, imm};
               rw = 1'b1; dst = rt_f;
            end
            mde_pkg::OP_ORI: begin
               res = rs | {16'd0, imm};
               rw = 1'b1; dst = rt_f;
            end
            mde_pkg::OP_LUI: begin
               res = {16'd0, imm} << mde_pkg::LUI_SHIFT;
               rw = 1'b1; dst = rt_f;
            end
            mde_pkg::OP_BEQ: begin
               if (rs == rt) begin
                  e.jump_taken  = 1'b1;
                  e.redirect_pc = btgt;
               end
            end
            mde_pkg::OP_BNE: begin
               if (rs != rt) begin
                  e.jump_taken  = 1'b1;
                  e.redirect_pc = btgt;
               end
            end
            mde_pkg::OP_J: begin
               e.jump_taken  = 1'b1;
               e.redirect_pc = jtgt;
            end
            mde_pkg::OP_JAL: begin
               e.jump_taken  = 1'b1;
               e.redirect_pc = jtgt;
               res = npc + mde_pkg::LINK_OFS;
               rw  = 1'b1;
               dst = mde_pkg::LINK_REG;
            end
            default: st = mde_pkg::ST_BADOP;
         endcase
         e.alu_result = res;
         e.rd_write   = rw;
         e.dest_reg   = rw ? dst : 5'd0;
         // Any non-ok status squashes the instruction completely.
         if (st != mde_pkg::ST_OK) e = '0;
         e.status = st;
         return e;
      endfunction

      function void note_instruction(input logic [31:0] ins, input logic [31:0] rs,
                                     input logic [31:0] rt, input logic [31:0] npc);
         pending_results.push_back(decode_execute(ins, rs, rt, npc));
      endfunction

      task check_result(input mde_pkg::exe_type got);
         mde_pkg::exe_type want;
         if (pending_results.size() == 0) begin
            report_mismatch("response beat with nothing pending", got.alu_result, '0);
         end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status)
               report_mismatch("status", got.status, want.status);
            if (got.alu_result !== want.alu_result)
               report_mismatch("alu_result", got.alu_result, want.alu_result);
            if (got.dest_reg !== want.dest_reg)
               report_mismatch("dest_reg", got.dest_reg, want.dest_reg);
            if (got.rd_write !== want.rd_write)
               report_mismatch("rd_write", got.rd_write, want.rd_write);
            if (got.load_en !== want.load_en)
               report_mismatch("load_en", got.load_en, want.load_en);
            if (got.store_en !== want.store_en)
               report_mismatch("store_en", got.store_en, want.store_en);
            if (got.load_to_rd !== want.load_to_rd)
               report_mismatch("load_to_rd", got.load_to_rd, want.load_to_rd);
            if (got.store_data !== want.store_data)
               report_mismatch("store_data", got.store_data, want.store_data);
            if (got.jump_taken !== want.jump_taken)
               report_mismatch("jump_taken", got.jump_taken, want.jump_taken);
            if (got.redirect_pc !== want.redirect_pc)
               report_mismatch("redirect_pc", got.redirect_pc, want.redirect_pc);
            if (got.flush_fetch !== want.flush_fetch)
               report_mismatch("flush_fetch", got.flush_fetch, want.flush_fetch);
         end
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_instruction;
   logic [31:0] req_rs_operand;
   logic [31:0] req_rt_operand;
   logic [31:0] req_next_pc;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_alu_result;
   logic [4:0]  rsp_dest_reg;
   logic        rsp_rd_write;
   logic        rsp_load_en;
   logic        rsp_store_en;
   logic        rsp_load_to_rd;
   logic [31:0] rsp_store_data;
   logic        rsp_jump_taken;
   logic [31:0] rsp_redirect_pc;
   logic        rsp_flush_fetch;

   // Percentages of cycles in which the sender idles and the receiver stalls.
   int unsigned idle_pct;
   int unsigned stall_pct;
   int unsigned quiet_cycles;

   decode_exec_scoreboard sb = new();
   mde_pkg::exe_type seen;

   mips_decode_execute_core dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The receiver's stall is redrawn every cycle from the current phase's rate.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // Both channels are sampled at the rising edge, before any of this edge's
   // nonblocking updates land, so the values seen are the ones the edge captured.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_instruction(req_instruction, req_rs_operand, req_rt_operand,
                                req_next_pc);
         if (rsp_valid && !rsp_stall) begin
            seen.status      = rsp_status;
            seen.alu_result  = rsp_alu_result;
            seen.dest_reg    = rsp_dest_reg;
            seen.rd_write    = rsp_rd_write;
            seen.load_en     = rsp_load_en;
            seen.store_en    = rsp_store_en;
            seen.load_to_rd  = rsp_load_to_rd;
            seen.store_data  = rsp_store_data;
            seen.jump_taken  = rsp_jump_taken;
            seen.redirect_pc = rsp_redirect_pc;
            seen.flush_fetch = rsp_flush_fetch;
            sb.check_result(seen);
         end
      end
   end

   // The watchdog restarts its count on every accepted beat, so a long run is
   // fine as long as the block keeps making progress.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb NOT OK");
            $finish;
         end
      end
   end

   // Hands one instruction beat to the block. Optional idle cycles come first,
   // then the beat is held steady until the block takes it.
   task automatic send_beat(input logic [31:0] ins, input logic [31:0] rs,
                            input logic [31:0] rt, input logic [31:0] npc);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_instruction <= ins;
      req_rs_operand  <= rs;
      req_rt_operand  <= rt;
      req_next_pc     <= npc;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic logic [31:0] r_word(input logic [5:0] fn, input logic [4:0] rs_n,
                                          input logic [4:0] rt_n, input logic [4:0] rd_n,
                                          input logic [4:0] sh);
      return {mde_pkg::OP_R, rs_n, rt_n, rd_n, sh, fn};
   endfunction

   function automatic logic [31:0] i_word(input logic [5:0] op, input logic [4:0] rs_n,
                                          input logic [4:0] rt_n, input logic [15:0] imm);
      return {op, rs_n, rt_n, imm};
   endfunction

   // Operands lean toward the values where signed and unsigned arithmetic
   // disagree or overflow, with plain random words for the rest.
   function automatic logic [31:0] random_operand();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'hFFFF_FFFF;
         4: return $urandom_range(0, 32) - 32'd16;
         default: return $urandom();
      endcase
   endfunction

   // Mostly well-formed instructions with random fields; a small share is an
   // arbitrary word, which usually lands on an unknown opcode.
   function automatic logic [31:0] random_instruction();
      logic [31:0] word;
      logic [5:0]  op;
      logic [5:0]  fn;
      word = $urandom();
      if ($urandom_range(0, 99) < 8) return word;
      if ($urandom_range(0, 99) < 40) begin
         op = mde_pkg::OP_R;
      end else begin
         case ($urandom_range(0, 12))
            0:  op = mde_pkg::OP_J;
            1:  op = mde_pkg::OP_JAL;
            2:  op = mde_pkg::OP_BEQ;
            3:  op = mde_pkg::OP_BNE;
            4:  op = mde_pkg::OP_ADDI;
            5:  op = mde_pkg::OP_ADDIU;
            6:  op = mde_pkg::OP_SLTI;
            7:  op = mde_pkg::OP_SLTIU;
            8:  op = mde_pkg::OP_ANDI;
            9:  op = mde_pkg::OP_ORI;
            10: op = mde_pkg::OP_LUI;
            11: op = mde_pkg::OP_LW;
            default: op = mde_pkg::OP_SW;
         endcase
      end
      fn = word[5:0];
      if (op == mde_pkg::OP_R && $urandom_range(0, 99) < 92) begin
         case ($urandom_range(0, 12))
            0:  fn = mde_pkg::FN_SLL;
            1:  fn = mde_pkg::FN_SRL;
            2:  fn = mde_pkg::FN_JR;
            3:  fn = mde_pkg::FN_SYS;
            4:  fn = mde_pkg::FN_ADD;
            5:  fn = mde_pkg::FN_ADDU;
            6:  fn = mde_pkg::FN_SUB;
            7:  fn = mde_pkg::FN_SUBU;
            8:  fn = mde_pkg::FN_AND;
            9:  fn = mde_pkg::FN_OR;
            10: fn = mde_pkg::FN_NOR;
            11: fn = mde_pkg::FN_SLT;
            default: fn = mde_pkg::FN_SLTU;
         endcase
      end
      // Immediates at the sign boundary are worth seeing often.
      if ($urandom_range(0, 3) == 0) begin
         case ($urandom_range(0, 3))
            0: word[15:0] = 16'h7FFF;
            1: word[15:0] = 16'h8000;
            2: word[15:0] = 16'hFFFF;
            default: word[15:0] = 16'h0000;
         endcase
      end
      word[31:26] = op;
      if (op == mde_pkg::OP_R) word[5:0] = fn;
      return word;
   endfunction

   initial begin
      logic [31:0] rs_val;
      logic [31:0] rt_val;
      clock           = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_instruction = '0;
      req_rs_operand  = '0;
      req_rt_operand  = '0;
      req_next_pc     = '0;
      rsp_stall       = 1'b0;
      idle_pct        = 0;
      stall_pct       = 0;
      quiet_cycles    = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed beats: every funct and opcode once, each picked to hit an edge
      // case such as a shift by 31, a signed overflow, a wrapping branch target
      // or a squashed instruction.
      send_beat(r_word(mde_pkg::FN_SLL, 5'd0, 5'd31, 5'd31, 5'd31),
                32'h0, 32'hFFFF_FFFF, 32'h0);
      send_beat(r_word(mde_pkg::FN_SRL, 5'd1, 5'd2, 5'd3, 5'd31),
                32'h0, 32'h8000_0000, 32'h4);
      send_beat(r_word(mde_pkg::FN_JR, 5'd31, 5'd0, 5'd0, 5'd0),
                32'hFFFF_FFFC, 32'h1, 32'h8);
      send_beat(r_word(mde_pkg::FN_SYS, 5'd4, 5'd5, 5'd6, 5'd0),
                32'h1234_5678, 32'h1, 32'hC);
      send_beat(r_word(mde_pkg::FN_ADD, 5'd1, 5'd2, 5'd3, 5'd0),
                32'h7FFF_FFFF, 32'h1, 32'h10);
      send_beat(r_word(mde_pkg::FN_ADDU, 5'd1, 5'd2, 5'd0, 5'd0),
                32'hFFFF_FFFF, 32'h1, 32'h14);
      send_beat(r_word(mde_pkg::FN_SUB, 5'd1, 5'd2, 5'd7, 5'd0),
                32'h8000_0000, 32'h1, 32'h18);
      send_beat(r_word(mde_pkg::FN_SUBU, 5'd1, 5'd2, 5'd8, 5'd0),
                32'h0, 32'h1, 32'h1C);
      send_beat(r_word(mde_pkg::FN_AND, 5'd1, 5'd2, 5'd9, 5'd0),
                32'hFFFF_FFFF, 32'hA5A5_A5A5, 32'h20);
      send_beat(r_word(mde_pkg::FN_OR, 5'd1, 5'd2, 5'd10, 5'd0),
                32'h0F0F_0F0F, 32'hF000_0000, 32'h24);
      send_beat(r_word(mde_pkg::FN_NOR, 5'd0, 5'd0, 5'd11, 5'd0),
                32'h0, 32'h0, 32'h28);
      send_beat(r_word(mde_pkg::FN_SLT, 5'd1, 5'd2, 5'd12, 5'd0),
                32'h8000_0000, 32'h7FFF_FFFF, 32'h2C);
      send_beat(r_word(mde_pkg::FN_SLTU, 5'd1, 5'd2, 5'd13, 5'd0),
                32'h8000_0000, 32'h7FFF_FFFF, 32'h30);
      send_beat(r_word(FN_UNUSED, 5'd1, 5'd2, 5'd14, 5'd0), 32'h1, 32'h2, 32'h34);
      send_beat({mde_pkg::OP_J, 26'h3FF_FFFF}, 32'h0, 32'h0, 32'hF000_0000);
      send_beat({mde_pkg::OP_JAL, 26'h000_0000}, 32'h0, 32'h0, 32'hFFFF_FFFF);
      send_beat(i_word(mde_pkg::OP_BEQ, 5'd1, 5'd2, 16'h8000),
                32'h1234_5678, 32'h1234_5678, 32'h10);
      send_beat(i_word(mde_pkg::OP_BNE, 5'd1, 5'd2, 16'h7FFF),
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h40);
      send_beat(i_word(mde_pkg::OP_ADDI, 5'd1, 5'd2, 16'h0001),
                32'h7FFF_FFFF, 32'h0, 32'h44);
      send_beat(i_word(mde_pkg::OP_ADDIU, 5'd1, 5'd31, 16'h8000), 32'h0, 32'h0, 32'h48);
      send_beat(i_word(mde_pkg::OP_SLTI, 5'd1, 5'd3, 16'hFFFF),
                32'h8000_0000, 32'h0, 32'h4C);
      send_beat(i_word(mde_pkg::OP_SLTIU, 5'd1, 5'd4, 16'h8000), 32'h0, 32'h0, 32'h50);
      send_beat(i_word(mde_pkg::OP_ANDI, 5'd1, 5'd5, 16'hFFFF),
                32'hFFFF_FFFF, 32'h0, 32'h54);
      send_beat(i_word(mde_pkg::OP_ORI, 5'd1, 5'd6, 16'h8000), 32'h0, 32'h0, 32'h58);
      send_beat(i_word(mde_pkg::OP_LUI, 5'd0, 5'd7, 16'hFFFF), 32'h0, 32'h0, 32'h5C);
      send_beat(i_word(mde_pkg::OP_LW, 5'd1, 5'd8, 16'hFFFF), 32'h0, 32'h0, 32'h60);
      send_beat(i_word(mde_pkg::OP_SW, 5'd1, 5'd9, 16'h0001),
                32'hFFFF_FFFF, 32'hDEAD_BEEF, 32'h64);
      send_beat(i_word(OP_UNUSED, 5'd1, 5'd2, 16'h1234), 32'h1, 32'h2, 32'h68);

      // Random beats in four traffic phases: free flowing, a mostly idle
      // sender, a mostly stalled receiver, and light pressure on both sides.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 76; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 76; end
            default: begin idle_pct = 25; stall_pct = 25; end
         endcase
         for (int n = 0; n < BEATS_PER_PHASE; n++) begin
            rs_val = random_operand();
            // Equal operands give branches a fair chance of going both ways.
            rt_val = ($urandom_range(0, 3) == 0) ? rs_val : random_operand();
            send_beat(random_instruction(), rs_val, rt_val, $urandom());
         end
      end
      req_valid <= 1'b0;

      // Let the pipeline drain, then keep clocking it so that any beat that
      // should not be there shows up.
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/mde_pkg.sv
src/mde_decode.sv
src/mde_execute.sv
src/mips_decode_execute_core.sv
src/mde_checker.sv
test/tb.sv
